### hdl/y2p_pkg.sv
// Shared types, codes and helpers for the YUY2 to planar chroma resampler.
package y2p_pkg;

	localparam int MAX_PAIRS_DEF = 2048;
	localparam int MAX_ROWS_DEF  = 4096;

	// APB register map: register index sits at paddr[3:2]
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_PAIRS = 2'd1;
	localparam logic [1:0] REG_ROWS  = 2'd2;

	localparam logic [11:0] PAIRS_RST = 12'd360;
	localparam logic [12:0] ROWS_RST  = 13'd480;

	typedef enum logic [1:0] {
		MODE_422 = 2'd0,
		MODE_420 = 2'd1,
		MODE_411 = 2'd2,
		MODE_444 = 2'd3
	} mode_t;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_ONCE  = 2'd1;
	localparam logic [1:0] ACT_TWICE = 2'd2;

	typedef struct packed {
		mode_t       mode;
		logic [11:0] pairs_per_line;
		logic [12:0] rows_per_frame;
	} cfg_t;

	// Cb in the high byte, Cr in the low byte
	typedef struct packed {
		logic [7:0] cb;
		logic [7:0] cr;
	} chroma_t;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		chroma_t    chroma;
	} pix_t;

	typedef struct packed {
		mode_t mode;
		logic  lend;
		logic  fend;
		logic  last_row;
		logic  col_odd;
		logic  row_odd;
		logic  col_ok;
	} ctrl_t;

	function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

endpackage

### hdl/y2p_pix_if.sv
// Input channel: one packed YUY2 macropixel per beat.
interface y2p_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_first;
	logic [7:0] chroma_blue;
	logic [7:0] luma_second;
	logic [7:0] chroma_red;

	modport source(output valid, luma_first, chroma_blue, luma_second, chroma_red,
		input ready);
	modport sink(input valid, luma_first, chroma_blue, luma_second, chroma_red,
		output ready);
endinterface

### hdl/y2p_res_if.sv
// Output channel: luma pair plus planar chroma per beat.
interface y2p_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_luma_first;
	logic [7:0] out_luma_second;
	logic [7:0] out_blue;
	logic [7:0] out_red;
	logic [1:0] chroma_action;
	logic       line_end;
	logic       frame_end;

	modport source(output valid, out_luma_first, out_luma_second, out_blue, out_red,
		chroma_action, line_end, frame_end, input ready);
	modport sink(input valid, out_luma_first, out_luma_second, out_blue, out_red,
		chroma_action, line_end, frame_end, output ready);
endinterface

### hdl/y2p_cfg.sv
// APB configuration registers: target mode, line length, frame height.
module y2p_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [y2p_pkg::ADDR_W-1:0] paddr,
	input  logic [y2p_pkg::DATA_W-1:0] pwdata,
	output logic [y2p_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output y2p_pkg::cfg_t              cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode           <= y2p_pkg::MODE_422;
			cfg.pairs_per_line <= y2p_pkg::PAIRS_RST;
			cfg.rows_per_frame <= y2p_pkg::ROWS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				y2p_pkg::REG_MODE:  cfg.mode <= y2p_pkg::mode_t'(pwdata[1:0]);
				y2p_pkg::REG_PAIRS: cfg.pairs_per_line <= pwdata[11:0];
				y2p_pkg::REG_ROWS:  cfg.rows_per_frame <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			y2p_pkg::REG_MODE:  prdata = {30'd0, cfg.mode};
			y2p_pkg::REG_PAIRS: prdata = {20'd0, cfg.pairs_per_line};
			y2p_pkg::REG_ROWS:  prdata = {19'd0, cfg.rows_per_frame};
			default:            prdata = '0;
		endcase
	end

endmodule

### hdl/y2p_front.sv
// Input stage: position counters, pair hold register and chroma line store.
module y2p_front #(
	parameter int MAX_PAIRS = y2p_pkg::MAX_PAIRS_DEF,
	parameter int MAX_ROWS  = y2p_pkg::MAX_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  y2p_pkg::cfg_t    cfg,
	y2p_pix_if.sink          pix,
	input  logic             adv,
	output logic             valid_s1,
	output y2p_pkg::ctrl_t   ctrl_s1,
	output y2p_pkg::pix_t    pix_s1,
	output y2p_pkg::chroma_t held_s1,
	output y2p_pkg::chroma_t store_s1
);

	localparam int COL_W = $clog2(MAX_PAIRS);
	localparam int ROW_W = $clog2(MAX_ROWS);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	y2p_pkg::chroma_t  held_q;
	y2p_pkg::chroma_t  line_mem [MAX_PAIRS];

	logic [COL_W-1:0]  pairs_last;
	logic [ROW_W-1:0]  rows_last;
	logic              accept;
	logic              lend;
	logic              last_row;
	logic              fend;
	logic              col_ok;
	logic              store_wr;
	y2p_pkg::chroma_t  packed_c;

	assign pix.ready = !valid_s1 || adv;
	assign accept    = pix.valid && pix.ready;
	assign packed_c  = '{cb: pix.chroma_blue, cr: pix.chroma_red};

	// clamp the line and frame limits to 1..MAX
	always_comb begin
		if (cfg.pairs_per_line == '0)
			pairs_last = '0;
		else if (32'(cfg.pairs_per_line) > MAX_PAIRS)
			pairs_last = COL_W'(MAX_PAIRS - 1);
		else
			pairs_last = COL_W'(cfg.pairs_per_line - 12'd1);

		if (cfg.rows_per_frame == '0)
			rows_last = '0;
		else if (32'(cfg.rows_per_frame) > MAX_ROWS)
			rows_last = ROW_W'(MAX_ROWS - 1);
		else
			rows_last = ROW_W'(cfg.rows_per_frame - 13'd1);
	end

	assign lend     = col_q >= pairs_last;
	assign last_row = row_q >= rows_last;
	assign fend     = lend && last_row;
	assign col_ok   = 32'(col_q) < MAX_PAIRS;
	assign store_wr = (cfg.mode == y2p_pkg::MODE_420) && !row_q[0] && col_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (lend) begin
					col_q <= '0;
					row_q <= fend ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				if (cfg.mode == y2p_pkg::MODE_411 && !col_q[0])
					held_q <= packed_c;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1.mode     <= cfg.mode;
			ctrl_s1.lend     <= lend;
			ctrl_s1.fend     <= fend;
			ctrl_s1.last_row <= last_row;
			ctrl_s1.col_odd  <= col_q[0];
			ctrl_s1.row_odd  <= row_q[0];
			ctrl_s1.col_ok   <= col_ok;
			pix_s1.luma_first  <= pix.luma_first;
			pix_s1.luma_second <= pix.luma_second;
			pix_s1.chroma      <= packed_c;
			held_s1            <= held_q;
		end
	end

	// even rows write, odd rows use the read; every beat reads and sees the old entry
	always_ff @(posedge clk) begin
		if (accept) begin
			if (store_wr)
				line_mem[col_q] <= packed_c;
			store_s1 <= line_mem[col_q];
		end
	end

endmodule

### hdl/y2p_back.sv
// Chroma selection and averaging into the output register.
module y2p_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  y2p_pkg::ctrl_t   ctrl_s1,
	input  y2p_pkg::pix_t    pix_s1,
	input  y2p_pkg::chroma_t held_s1,
	input  y2p_pkg::chroma_t store_s1,
	output logic             adv,
	y2p_res_if.source        res
);

	logic       valid_s2;
	logic [7:0] luma_first_s2;
	logic [7:0] luma_second_s2;
	logic [7:0] blue_s2;
	logic [7:0] red_s2;
	logic [1:0] act_s2;
	logic       lend_s2;
	logic       fend_s2;

	logic [7:0] ob;
	logic [7:0] orr;
	logic [1:0] act;

	assign adv = !valid_s2 || res.ready;

	always_comb begin
		ob  = '0;
		orr = '0;
		act = y2p_pkg::ACT_NONE;
		unique case (ctrl_s1.mode)
			y2p_pkg::MODE_422: begin
				ob  = pix_s1.chroma.cb;
				orr = pix_s1.chroma.cr;
				act = y2p_pkg::ACT_ONCE;
			end
			y2p_pkg::MODE_444: begin
				ob  = pix_s1.chroma.cb;
				orr = pix_s1.chroma.cr;
				act = y2p_pkg::ACT_TWICE;
			end
			y2p_pkg::MODE_411: begin
				if (ctrl_s1.col_odd) begin
					ob  = y2p_pkg::avg8(held_s1.cb, pix_s1.chroma.cb);
					orr = y2p_pkg::avg8(held_s1.cr, pix_s1.chroma.cr);
					act = y2p_pkg::ACT_ONCE;
				end
			end
			y2p_pkg::MODE_420: begin
				if (ctrl_s1.col_ok) begin
					if (ctrl_s1.row_odd) begin
						ob  = y2p_pkg::avg8(store_s1.cb, pix_s1.chroma.cb);
						orr = y2p_pkg::avg8(store_s1.cr, pix_s1.chroma.cr);
						act = y2p_pkg::ACT_ONCE;
					end else if (ctrl_s1.last_row) begin
						// odd-height frame: last even row has no partner
						ob  = pix_s1.chroma.cb;
						orr = pix_s1.chroma.cr;
						act = y2p_pkg::ACT_ONCE;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			luma_first_s2  <= pix_s1.luma_first;
			luma_second_s2 <= pix_s1.luma_second;
			blue_s2        <= ob;
			red_s2         <= orr;
			act_s2         <= act;
			lend_s2        <= ctrl_s1.lend;
			fend_s2        <= ctrl_s1.fend;
		end
	end

	assign res.valid           = valid_s2;
	assign res.out_luma_first  = luma_first_s2;
	assign res.out_luma_second = luma_second_s2;
	assign res.out_blue        = blue_s2;
	assign res.out_red         = red_s2;
	assign res.chroma_action   = act_s2;
	assign res.line_end        = lend_s2;
	assign res.frame_end       = fend_s2;

endmodule

### hdl/yuy2_to_planar_chroma_resampler_unit.sv
// Top level: packed YUY2 macropixels in, planar luma/chroma writes out.
//
//  channel | dir | handshake     | beat
//  pix     | in  | valid/ready   | luma_first, chroma_blue, luma_second, chroma_red
//  res     | out | valid/ready   | luma pair, out_blue/out_red, chroma_action, line/frame end
//  apb     | in  | psel/penable  | target_mode @0x0, pairs_per_line @0x4, rows_per_frame @0x8
//
// One beat per cycle sustained while res accepts; a result passes the input register
// (with line store read), then the output register.
// The line store is read and written at the input register's edge, so rows of one
// macropixel still see the previous row's chroma without a bypass.
// Reset clears counters, pair hold and valids; the line store has no clearing pass.
// pix.ready drops only while both stages are full and res is stalled.
module yuy2_to_planar_chroma_resampler_unit #(
	parameter int MAX_PAIRS = y2p_pkg::MAX_PAIRS_DEF,
	parameter int MAX_ROWS  = y2p_pkg::MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	y2p_pix_if.sink                    pix,
	y2p_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [y2p_pkg::ADDR_W-1:0] paddr,
	input  logic [y2p_pkg::DATA_W-1:0] pwdata,
	output logic [y2p_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	y2p_pkg::cfg_t    cfg;
	logic             adv;
	logic             valid_s1;
	y2p_pkg::ctrl_t   ctrl_s1;
	y2p_pkg::pix_t    pix_s1;
	y2p_pkg::chroma_t held_s1;
	y2p_pkg::chroma_t store_s1;

	y2p_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	y2p_front #(
		.MAX_PAIRS (MAX_PAIRS),
		.MAX_ROWS  (MAX_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pix      (pix),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.ctrl_s1  (ctrl_s1),
		.pix_s1   (pix_s1),
		.held_s1  (held_s1),
		.store_s1 (store_s1)
	);

	y2p_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ctrl_s1  (ctrl_s1),
		.pix_s1   (pix_s1),
		.held_s1  (held_s1),
		.store_s1 (store_s1),
		.adv      (adv),
		.res      (res)
	);

endmodule

### hdl/y2p_checker.sv
// Port-level checks for the resampler, bound to the top level.
module y2p_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_luma_first,
	input logic [7:0] out_luma_second,
	input logic [7:0] out_blue,
	input logic [7:0] out_red,
	input logic [1:0] chroma_action,
	input logic       line_end,
	input logic       frame_end
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_beat_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(out_luma_first) && $stable(out_luma_second)
			&& $stable(out_blue) && $stable(out_red) && $stable(chroma_action)
			&& $stable(line_end) && $stable(frame_end))
		else $error("result beat changed while stalled");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> chroma_action <= y2p_pkg::ACT_TWICE)
		else $error("illegal chroma action");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && chroma_action == y2p_pkg::ACT_NONE |-> out_blue == 8'd0 && out_red == 8'd0)
		else $error("chroma present without a write");

	a_frame_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> line_end)
		else $error("frame end outside a line end");

endmodule

bind yuy2_to_planar_chroma_resampler_unit y2p_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.out_luma_first  (res.out_luma_first),
	.out_luma_second (res.out_luma_second),
	.out_blue        (res.out_blue),
	.out_red         (res.out_red),
	.chroma_action   (res.chroma_action),
	.line_end        (res.line_end),
	.frame_end       (res.frame_end)
);

### tb/tb.sv
// Self-checking bench for the YUY2 to planar chroma resampler: directed and random frames.
`timescale 1ns / 1ps
module tb;

	localparam int CLK_HALF     = 6;
	localparam int TIMEOUT_NS   = 10_000_000;
	localparam int RANDOM_ITEMS = 1600;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] blue;
		logic [7:0] red;
		logic [1:0] action;
		logic       line_end;
		logic       frame_end;
	} planar_beat_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [y2p_pkg::ADDR_W-1:0] paddr;
	logic [y2p_pkg::DATA_W-1:0] pwdata;
	logic [y2p_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	y2p_pix_if pix();
	y2p_res_if res();

	yuy2_to_planar_chroma_resampler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// resampler shadow: configuration, position and chroma memories
	y2p_pkg::mode_t   cur_mode;
	logic [11:0]      cfg_pairs;
	logic [12:0]      cfg_rows;
	logic [10:0]      col_cnt;
	logic [11:0]      row_cnt;
	y2p_pkg::chroma_t pair_hold;
	y2p_pkg::chroma_t line_mem [y2p_pkg::MAX_PAIRS_DEF];
	bit               line_written [y2p_pkg::MAX_PAIRS_DEF];

	planar_beat_t pending [$];
	int unsigned  items_sent;
	int unsigned  beats_checked;
	int unsigned  error_count;
	int unsigned  hold_off;
	bit           gaps_on;

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic void note_error(input string msg);
		if (error_count < 10) $display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endfunction

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [7:0] chroma_mean(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic y2p_pkg::pix_t mk_pix(input logic [7:0] lf, cb, ls, cr);
		y2p_pkg::pix_t p;
		p.luma_first  = lf;
		p.luma_second = ls;
		p.chroma.cb   = cb;
		p.chroma.cr   = cr;
		return p;
	endfunction

	function automatic y2p_pkg::pix_t rand_pix();
		return mk_pix($urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	function automatic string beat_text(input planar_beat_t b);
		return $sformatf("y %02h/%02h cb %02h cr %02h act %0d le %0b fe %0b",
			b.luma_first, b.luma_second, b.blue, b.red, b.action, b.line_end, b.frame_end);
	endfunction

	function automatic planar_beat_t resample_macropixel(input y2p_pkg::pix_t p);
		planar_beat_t     r;
		int unsigned      eff_pairs;
		int unsigned      eff_rows;
		logic             last_row;
		y2p_pkg::chroma_t above;
		eff_pairs     = clamp_size(cfg_pairs, y2p_pkg::MAX_PAIRS_DEF);
		eff_rows      = clamp_size(cfg_rows, y2p_pkg::MAX_ROWS_DEF);
		r             = '0;
		r.luma_first  = p.luma_first;
		r.luma_second = p.luma_second;
		// counters past a lowered limit end the line / frame right away
		r.line_end    = (col_cnt >= eff_pairs - 1);
		last_row      = (row_cnt >= eff_rows - 1);
		r.frame_end   = r.line_end && last_row;
		case (cur_mode)
			y2p_pkg::MODE_422: begin
				r.blue   = p.chroma.cb;
				r.red    = p.chroma.cr;
				r.action = y2p_pkg::ACT_ONCE;
			end
			y2p_pkg::MODE_444: begin
				r.blue   = p.chroma.cb;
				r.red    = p.chroma.cr;
				r.action = y2p_pkg::ACT_TWICE;
			end
			y2p_pkg::MODE_411: begin
				if (!col_cnt[0]) begin
					pair_hold = p.chroma;
				end else begin
					r.blue   = chroma_mean(pair_hold.cb, p.chroma.cb);
					r.red    = chroma_mean(pair_hold.cr, p.chroma.cr);
					r.action = y2p_pkg::ACT_ONCE;
				end
			end
			default: begin
				if (!row_cnt[0]) begin
					line_mem[col_cnt]     = p.chroma;
					line_written[col_cnt] = 1'b1;
					// odd-height frame: last even row has no partner row
					if (last_row) begin
						r.blue   = p.chroma.cb;
						r.red    = p.chroma.cr;
						r.action = y2p_pkg::ACT_ONCE;
					end
				end else begin
					if (!line_written[col_cnt])
						note_error($sformatf("line store column %0d read unwritten", col_cnt));
					above    = line_mem[col_cnt];
					r.blue   = chroma_mean(above.cb, p.chroma.cb);
					r.red    = chroma_mean(above.cr, p.chroma.cr);
					r.action = y2p_pkg::ACT_ONCE;
				end
			end
		endcase
		if (r.line_end) begin
			col_cnt = '0;
			row_cnt = r.frame_end ? 12'd0 : row_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_pairs();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom_range(9, 64);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [31:0] pick_rows();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom_range(7, 20);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_pix(input y2p_pkg::pix_t p);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid       <= 1'b1;
		pix.luma_first  <= p.luma_first;
		pix.chroma_blue <= p.chroma.cb;
		pix.luma_second <= p.luma_second;
		pix.chroma_red  <= p.chroma.cr;
		do @(posedge clk); while (!pix.ready);
		pending.push_back(resample_macropixel(p));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pix.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// only while idle: write, update the shadow, read back
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(idx, 1'b1, value, rd);
		want = '0;
		case (idx)
			y2p_pkg::REG_MODE: begin
				cur_mode   = y2p_pkg::mode_t'(value[1:0]);
				want[1:0]  = value[1:0];
			end
			y2p_pkg::REG_PAIRS: begin
				cfg_pairs  = value[11:0];
				want[11:0] = value[11:0];
			end
			y2p_pkg::REG_ROWS: begin
				cfg_rows   = value[12:0];
				want[12:0] = value[12:0];
			end
			default: ;
		endcase
		apb_access(idx, 1'b0, '0, rd);
		if (rd !== want)
			note_error($sformatf("register %0d reads %0h, want %0h", idx, rd, want));
	endtask

	// bring the counters back to the top of a frame, then load a mode and a geometry
	task automatic start_frame(input y2p_pkg::mode_t m, input logic [31:0] p,
		input logic [31:0] r);
		drain();
		if (col_cnt != 0 || row_cnt != 0) begin
			write_reg(y2p_pkg::REG_PAIRS, 32'd1);
			write_reg(y2p_pkg::REG_ROWS, 32'd1);
			send_pix(rand_pix());
			drain();
		end
		write_reg(y2p_pkg::REG_MODE, 32'(m));
		write_reg(y2p_pkg::REG_PAIRS, p);
		write_reg(y2p_pkg::REG_ROWS, r);
	endtask

	// mid-frame change; 4:2:0 is only ever entered at a frame start
	task automatic shift_settings();
		drain();
		case ($urandom_range(0, 2))
			0: begin
				case ($urandom_range(0, 2))
					0: write_reg(y2p_pkg::REG_MODE, 32'(y2p_pkg::MODE_422));
					1: write_reg(y2p_pkg::REG_MODE, 32'(y2p_pkg::MODE_411));
					default: write_reg(y2p_pkg::REG_MODE, 32'(y2p_pkg::MODE_444));
				endcase
			end
			1: write_reg(y2p_pkg::REG_ROWS, pick_rows());
			default: if (cur_mode != y2p_pkg::MODE_420) write_reg(y2p_pkg::REG_PAIRS, pick_pairs());
		endcase
	endtask

	task automatic test_register_reset();
		logic [31:0] rd;
		logic [1:0]  regs [3] = '{y2p_pkg::REG_MODE, y2p_pkg::REG_PAIRS, y2p_pkg::REG_ROWS};
		logic [31:0] want [3] = '{32'(y2p_pkg::MODE_422), 32'(y2p_pkg::PAIRS_RST),
			32'(y2p_pkg::ROWS_RST)};
		for (int i = 0; i < 3; i++) begin
			apb_access(regs[i], 1'b0, '0, rd);
			if (rd !== want[i])
				note_error($sformatf("register %0d reads %0h after reset, want %0h",
					regs[i], rd, want[i]));
		end
	endtask

	task automatic test_chroma_modes();
		send_pix(mk_pix(8'h00, 8'h00, 8'h00, 8'h00));
		send_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_pix(mk_pix(8'h00, 8'hFF, 8'hFF, 8'h00));
		send_pix(mk_pix(8'hFF, 8'h00, 8'h00, 8'hFF));
		drain();
		write_reg(y2p_pkg::REG_MODE, 32'(y2p_pkg::MODE_444));
		send_pix(mk_pix(8'hFF, 8'h00, 8'h00, 8'hFF));
		send_pix(rand_pix());
		// odd line length leaves a lone trailing pair with no chroma
		start_frame(y2p_pkg::MODE_411, 32'd3, 32'd2);
		send_pix(mk_pix(8'h11, 8'hFF, 8'h22, 8'hFF));
		send_pix(mk_pix(8'h33, 8'hFF, 8'h44, 8'hFF));
		send_pix(rand_pix());
		send_pix(mk_pix(8'h55, 8'h01, 8'h66, 8'h00));
		send_pix(mk_pix(8'h77, 8'h00, 8'h88, 8'h01));
		send_pix(rand_pix());
		// three rows: store, average, then the unpaired last row goes straight out
		start_frame(y2p_pkg::MODE_420, 32'd2, 32'd3);
		send_pix(mk_pix(8'h01, 8'hFF, 8'h02, 8'h01));
		send_pix(mk_pix(8'h03, 8'h00, 8'h04, 8'hFF));
		send_pix(mk_pix(8'h05, 8'hFF, 8'h06, 8'h00));
		send_pix(mk_pix(8'h07, 8'hFF, 8'h08, 8'hFF));
		send_pix(rand_pix());
		send_pix(rand_pix());
		// zero width and zero height both act as one
		start_frame(y2p_pkg::MODE_420, 32'd0, 32'd0);
		send_pix(rand_pix());
		send_pix(rand_pix());
	endtask

	task automatic test_mode_switch_hold();
		start_frame(y2p_pkg::MODE_411, 32'd4, 32'd1);
		send_pix(mk_pix(8'h10, 8'hC8, 8'h20, 8'h64));
		drain();
		write_reg(y2p_pkg::REG_MODE, 32'(y2p_pkg::MODE_422));
		send_pix(rand_pix());
		send_pix(rand_pix());
		drain();
		// odd column pairs with the chroma held three beats earlier
		write_reg(y2p_pkg::REG_MODE, 32'(y2p_pkg::MODE_411));
		send_pix(rand_pix());
	endtask

	task automatic test_shrunk_limits();
		start_frame(y2p_pkg::MODE_422, 32'd2048, 32'd4096);
		repeat (5) send_pix(rand_pix());
		drain();
		write_reg(y2p_pkg::REG_PAIRS, 32'd2);
		repeat (5) send_pix(rand_pix());
		drain();
		write_reg(y2p_pkg::REG_ROWS, 32'd2);
		repeat (2) send_pix(rand_pix());
	endtask

	task automatic test_backpressure();
		start_frame(y2p_pkg::MODE_444, 32'd16, 32'd64);
		gaps_on  = 1'b0;
		hold_off = 120;
		repeat (60) send_pix(rand_pix());
		drain();
		gaps_on = 1'b1;
		repeat (20) send_pix(rand_pix());
	endtask

	// 4095 pairs clamp to the maximum, so no line end early in the line
	task automatic test_line_clamp();
		gaps_on = $urandom_range(0, 1);
		start_frame(y2p_pkg::MODE_420, 32'd4095, 32'd1);
		repeat (64) send_pix(rand_pix());
		gaps_on = 1'b1;
	endtask

	// 8191 rows clamp to the maximum, one pair per line
	task automatic test_row_clamp();
		gaps_on = $urandom_range(0, 1);
		start_frame(y2p_pkg::MODE_420, 32'd0, 32'd8191);
		repeat (64) send_pix(rand_pix());
		gaps_on = 1'b1;
	endtask

	task automatic test_random_frames(input int unsigned target);
		int unsigned    start_count;
		int unsigned    left;
		int unsigned    chunk;
		y2p_pkg::mode_t m;
		logic [31:0]    p;
		logic [31:0]    r;
		start_count = items_sent;
		while (items_sent - start_count < target) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			m       = y2p_pkg::mode_t'($urandom_range(0, 3));
			p       = pick_pairs();
			r       = pick_rows();
			start_frame(m, p, r);
			left = clamp_size(p, y2p_pkg::MAX_PAIRS_DEF) * clamp_size(r, y2p_pkg::MAX_ROWS_DEF);
			if (left > 160) left = 160;
			while (left > 0) begin
				chunk = $urandom_range(1, left);
				repeat (chunk) send_pix(rand_pix());
				left -= chunk;
				if (left > 0 && $urandom_range(0, 2) == 0) shift_settings();
			end
		end
		gaps_on = 1'b1;
	endtask

	// result side: random stalls per beat, plus a long hold-off on request
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(0, 8) : 0;
			if (hold_off > 0) begin
				stall    = hold_off;
				hold_off = 0;
			end
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_beats
		planar_beat_t seen;
		planar_beat_t want;
		if (arst_n && res.valid && res.ready) begin
			seen.luma_first  = res.out_luma_first;
			seen.luma_second = res.out_luma_second;
			seen.blue        = res.out_blue;
			seen.red         = res.out_red;
			seen.action      = res.chroma_action;
			seen.line_end    = res.line_end;
			seen.frame_end   = res.frame_end;
			if (pending.size() == 0) begin
				note_error($sformatf("unexpected beat: %s", beat_text(seen)));
			end else begin
				want = pending.pop_front();
				if (seen !== want)
					note_error($sformatf("beat %0d: want %s, got %s", beats_checked,
						beat_text(want), beat_text(seen)));
			end
			beats_checked++;
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("watchdog expired with %0d beats outstanding", pending.size());
		$display("yuy2_to_planar_chroma_resampler_unit test failed");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		pix.valid       = 1'b0;
		pix.luma_first  = '0;
		pix.chroma_blue = '0;
		pix.luma_second = '0;
		pix.chroma_red  = '0;
		res.ready       = 1'b0;
		cur_mode        = y2p_pkg::MODE_422;
		cfg_pairs       = y2p_pkg::PAIRS_RST;
		cfg_rows        = y2p_pkg::ROWS_RST;
		col_cnt         = '0;
		row_cnt         = '0;
		pair_hold       = '0;
		items_sent      = 0;
		beats_checked   = 0;
		error_count     = 0;
		hold_off        = 0;
		gaps_on         = 1'b1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_reset();
		test_chroma_modes();
		test_mode_switch_hold();
		test_shrunk_limits();
		test_backpressure();
		test_line_clamp();
		test_row_clamp();
		test_random_frames(RANDOM_ITEMS);

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d macropixels and %0d checked beats over all four target formats,",
			items_sent, beats_checked);
		$display("size clamps, lowered limits, mid-frame mode changes and stalls; %0d errors.",
			error_count);
		if (error_count == 0 && pending.size() == 0) begin
			$display("yuy2_to_planar_chroma_resampler_unit test passed");
		end else begin
			$display("yuy2_to_planar_chroma_resampler_unit test failed");
		end
		$finish;
	end

endmodule
